// ===== rtl/core/bhq_pkg.sv =====
// Shared types, codes and the sequencer microcode for the binary min-heap queue.
package bhq_pkg;

  localparam int unsigned IdW    = 31;
  localparam int unsigned KeyW   = 32;
  localparam int unsigned OutW   = 32;
  localparam int unsigned CountW = 11;
  localparam int unsigned StepW  = 5;

  localparam logic signed [OutW-1:0] ID_NONE = -32'sd1;

  // One heap slot: id above key
  typedef struct packed {
    logic [IdW-1:0]  id;
    logic [KeyW-1:0] key;
  } entry_t;

  typedef enum logic {
    REQ_INSERT  = 1'b0,
    REQ_EXTRACT = 1'b1
  } req_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_e;

  // Microprogram addresses
  typedef enum logic [StepW-1:0] {
    S_IDLE  = 5'd0,
    S_DISP  = 5'd1,
    S_CHKF  = 5'd2,
    S_INS   = 5'd3,
    S_UPCHK = 5'd4,
    S_UPCMP = 5'd5,
    S_UPWR  = 5'd6,
    S_REJ   = 5'd7,
    S_EX0   = 5'd8,
    S_EX1   = 5'd9,
    S_EX2   = 5'd10,
    S_DNCHK = 5'd11,
    S_DNL   = 5'd12,
    S_DNR   = 5'd13,
    S_DNWR  = 5'd14,
    S_EMP   = 5'd15,
    S_FIN   = 5'd16,
    S_WAIT  = 5'd17
  } step_e;

  // Memory read address select
  typedef enum logic [2:0] {
    RD_NONE   = 3'd0,
    RD_PARENT = 3'd1,
    RD_LAST   = 3'd2,
    RD_LCHILD = 3'd3,
    RD_RCHILD = 3'd4
  } rd_sel_e;

  // Memory write select; WR_RD and WR_CAND only fire when the jump is taken
  typedef enum logic [1:0] {
    WR_NONE = 2'd0,
    WR_HOLD = 2'd1,
    WR_RD   = 2'd2,
    WR_CAND = 2'd3
  } wr_sel_e;

  // Position update; POS_PARENT and POS_CAND only fire when the jump is taken
  typedef enum logic [2:0] {
    POS_KEEP   = 3'd0,
    POS_ONE    = 3'd1,
    POS_NEW    = 3'd2,
    POS_PARENT = 3'd3,
    POS_CAND   = 3'd4
  } pos_op_e;

  typedef enum logic [1:0] {
    CNT_KEEP = 2'd0,
    CNT_INC  = 2'd1,
    CNT_DEC  = 2'd2
  } cnt_op_e;

  typedef enum logic [2:0] {
    RES_KEEP  = 3'd0,
    RES_INIT  = 3'd1,
    RES_ROOT  = 3'd2,
    RES_FULL  = 3'd3,
    RES_EMPTY = 3'd4
  } res_op_e;

  // Jump conditions
  typedef enum logic [3:0] {
    C_NEVER     = 4'd0,
    C_ALWAYS    = 4'd1,
    C_NO_START  = 4'd2,
    C_EXTRACT   = 4'd3,
    C_FULL      = 4'd4,
    C_AT_ROOT   = 4'd5,
    C_PARENT_GT = 4'd6,
    C_EMPTY     = 4'd7,
    C_ONE       = 4'd8,
    C_LEAF      = 4'd9,
    C_CHILD_LT  = 4'd10,
    C_OUT_FREE  = 4'd11
  } cond_e;

  typedef struct packed {
    rd_sel_e rd;
    wr_sel_e wr;
    pos_op_e pos;
    cnt_op_e cnt;
    logic    hold_ld;
    logic    best_ld;
    res_op_e res;
    logic    out_ld;
  } ctrl_t;

  typedef struct packed {
    ctrl_t ctrl;
    cond_e cond;
    step_e target;
  } uword_t;

  // Datapath status seen by the sequencer
  typedef struct packed {
    logic start;
    logic extract;
    logic full;
    logic at_root;
    logic parent_gt;
    logic empty;
    logic one;
    logic leaf;
    logic child_lt;
    logic out_free;
  } flags_t;

  // Microcode ROM: not taken falls through to the next step
  function automatic uword_t ucode(step_e s);
    uword_t w;
    w = '0;
    unique case (s)
      S_IDLE: begin
        w.cond   = C_NO_START;
        w.target = S_IDLE;
      end
      S_DISP: begin
        w.ctrl.res = RES_INIT;
        w.cond     = C_EXTRACT;
        w.target   = S_EX0;
      end
      S_CHKF: begin
        w.cond   = C_FULL;
        w.target = S_REJ;
      end
      S_INS: begin
        w.ctrl.cnt = CNT_INC;
        w.ctrl.pos = POS_NEW;
      end
      S_UPCHK: begin
        w.ctrl.rd = RD_PARENT;
        w.cond    = C_AT_ROOT;
        w.target  = S_UPWR;
      end
      S_UPCMP: begin
        w.ctrl.wr  = WR_RD;
        w.ctrl.pos = POS_PARENT;
        w.cond     = C_PARENT_GT;
        w.target   = S_UPCHK;
      end
      S_UPWR: begin
        w.ctrl.wr = WR_HOLD;
        w.cond    = C_ALWAYS;
        w.target  = S_FIN;
      end
      S_REJ: begin
        w.ctrl.res = RES_FULL;
        w.cond     = C_ALWAYS;
        w.target   = S_FIN;
      end
      S_EX0: begin
        w.cond   = C_EMPTY;
        w.target = S_EMP;
      end
      S_EX1: begin
        w.ctrl.res = RES_ROOT;
        w.ctrl.rd  = RD_LAST;
        w.ctrl.cnt = CNT_DEC;
        w.ctrl.pos = POS_ONE;
        w.cond     = C_ONE;
        w.target   = S_FIN;
      end
      S_EX2: begin
        w.ctrl.hold_ld = 1'b1;
      end
      S_DNCHK: begin
        w.ctrl.rd = RD_LCHILD;
        w.cond    = C_LEAF;
        w.target  = S_DNWR;
      end
      S_DNL: begin
        w.ctrl.rd      = RD_RCHILD;
        w.ctrl.best_ld = 1'b1;
      end
      S_DNR: begin
        w.ctrl.wr  = WR_CAND;
        w.ctrl.pos = POS_CAND;
        w.cond     = C_CHILD_LT;
        w.target   = S_DNCHK;
      end
      S_DNWR: begin
        w.ctrl.wr = WR_HOLD;
        w.cond    = C_ALWAYS;
        w.target  = S_FIN;
      end
      S_EMP: begin
        w.ctrl.res = RES_EMPTY;
        w.cond     = C_ALWAYS;
        w.target   = S_FIN;
      end
      S_FIN: begin
        w.ctrl.out_ld = 1'b1;
        w.cond        = C_OUT_FREE;
        w.target      = S_IDLE;
      end
      S_WAIT: begin
        w.cond   = C_ALWAYS;
        w.target = S_FIN;
      end
      default: begin
        w.cond   = C_ALWAYS;
        w.target = S_IDLE;
      end
    endcase
    return w;
  endfunction

endpackage

// ===== rtl/core/bhq_if.sv =====
// Request and response channel interfaces of the binary min-heap queue.
interface bhq_req_if;
  import bhq_pkg::*;

  logic            valid;
  logic            ready;
  logic            req_type;
  logic [IdW-1:0]  new_id;
  logic [KeyW-1:0] new_key;

  modport source (output valid, req_type, new_id, new_key, input ready);
  modport sink   (input valid, req_type, new_id, new_key, output ready);
endinterface

interface bhq_rsp_if;
  import bhq_pkg::*;

  logic                   valid;
  logic                   ready;
  logic signed [OutW-1:0] out_id;
  logic [KeyW-1:0]        out_key;
  logic [1:0]             status;
  logic [CountW-1:0]      entry_count;
  logic signed [OutW-1:0] peek_id;
  logic [KeyW-1:0]        peek_key;

  modport source (output valid, out_id, out_key, status, entry_count, peek_id, peek_key,
                  input ready);
  modport sink   (input valid, out_id, out_key, status, entry_count, peek_id, peek_key,
                  output ready);
endinterface

// ===== rtl/core/bhq_seq.sv =====
// Microcode sequencer: step counter, control ROM and conditional jump.
module bhq_seq (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  bhq_pkg::flags_t flags_i,
  output bhq_pkg::ctrl_t  ctrl_o,
  output logic            hit_o,
  output logic            idle_o
);
  import bhq_pkg::*;

  step_e  pc_q, pc_d;
  uword_t uw;
  logic   hit;

  assign uw = ucode(pc_q);

  // Condition select
  always_comb begin
    unique case (uw.cond)
      C_NEVER:     hit = 1'b0;
      C_ALWAYS:    hit = 1'b1;
      C_NO_START:  hit = !flags_i.start;
      C_EXTRACT:   hit = flags_i.extract;
      C_FULL:      hit = flags_i.full;
      C_AT_ROOT:   hit = flags_i.at_root;
      C_PARENT_GT: hit = flags_i.parent_gt;
      C_EMPTY:     hit = flags_i.empty;
      C_ONE:       hit = flags_i.one;
      C_LEAF:      hit = flags_i.leaf;
      C_CHILD_LT:  hit = flags_i.child_lt;
      C_OUT_FREE:  hit = flags_i.out_free;
      default:     hit = 1'b0;
    endcase
  end

  // Next step: jump target or fall through
  always_comb begin
    pc_d = hit ? uw.target : step_e'(pc_q + 5'd1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q <= S_IDLE;
    end else begin
      pc_q <= pc_d;
    end
  end

  assign ctrl_o = uw.ctrl;
  assign hit_o  = hit;
  assign idle_o = (pc_q == S_IDLE);

endmodule

// ===== rtl/core/binary_min_heap_queue_top.sv =====
// Binary min-heap priority queue: heap memory, datapath and microcoded control.
// One item at a time. Insert: the new entry climbs from the new last slot until it reaches
// the root or its parent is not larger; extract: the root is returned and the last entry
// sifts down until a leaf or no smaller child; full insert, empty or one-entry extract: no walk.
// Single read port: one read per level going up, two reads and a compare going down.
// Next word accepted in the cycle after the result loads. Reset clears count, sequencer and
// result valid; the heap memory is not cleared.
module binary_min_heap_queue_top #(
  parameter int unsigned CAPACITY = 1024
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  bhq_req_if.sink   req_i,
  bhq_rsp_if.source rsp_o
);
  import bhq_pkg::*;

  localparam int unsigned CntW  = $clog2(CAPACITY + 1);
  localparam int unsigned AddrW = $clog2(CAPACITY);

  // Heap storage, slot s lives at address s-1
  entry_t heap_mem_q [CAPACITY];

  logic [CntW-1:0] cnt_q, cnt_d;
  logic [CntW-1:0] pos_q, pos_d;
  logic [CntW-1:0] bpos_q;
  entry_t          hold_q, best_q, rd_q, root_q;
  req_e            req_q;

  logic signed [OutW-1:0] res_id_q;
  logic [KeyW-1:0]        res_key_q;
  status_e                res_st_q;

  logic                   rsp_valid_q;
  logic signed [OutW-1:0] rsp_id_q, rsp_peek_id_q;
  logic [KeyW-1:0]        rsp_key_q, rsp_peek_key_q;
  status_e                rsp_st_q;
  logic [CntW-1:0]        rsp_cnt_q;

  ctrl_t  ctrl;
  flags_t flags;
  logic   hit, idle, start;

  logic [CntW-1:0] parent, lchild, rslot, rslot_m1, wslot_m1, cand_pos;
  logic [AddrW-1:0] raddr, waddr;
  logic             rd_en, wr_en, right_ok;
  entry_t           cand, wdata;

  bhq_seq u_seq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .flags_i (flags),
    .ctrl_o  (ctrl),
    .hit_o   (hit),
    .idle_o  (idle)
  );

  assign req_i.ready = idle;
  assign start       = req_i.valid && req_i.ready;

  // Tree navigation
  assign parent = pos_q >> 1;
  assign lchild = {pos_q[CntW-2:0], 1'b0};

  // Child pick: right only when it exists and is strictly smaller than left
  assign right_ok = (bpos_q < cnt_q) && (rd_q.key < best_q.key);
  assign cand     = right_ok ? rd_q : best_q;
  assign cand_pos = right_ok ? (bpos_q + CntW'(1)) : bpos_q;

  // Status flags for the sequencer
  always_comb begin
    flags.start     = start;
    flags.extract   = (req_q == REQ_EXTRACT);
    flags.full      = (cnt_q == CntW'(CAPACITY));
    flags.at_root   = (pos_q == CntW'(1));
    flags.parent_gt = (rd_q.key > hold_q.key);
    flags.empty     = (cnt_q == '0);
    flags.one       = (cnt_q == CntW'(1));
    flags.leaf      = ({pos_q, 1'b0} > {1'b0, cnt_q});
    flags.child_lt  = (cand.key < hold_q.key);
    flags.out_free  = !rsp_valid_q || rsp_o.ready;
  end

  // Read address select
  always_comb begin
    unique case (ctrl.rd)
      RD_PARENT: rslot = parent;
      RD_LAST:   rslot = cnt_q;
      RD_LCHILD: rslot = lchild;
      RD_RCHILD: rslot = lchild + CntW'(1);
      default:   rslot = '0;
    endcase
  end
  assign rd_en    = (ctrl.rd != RD_NONE);
  assign rslot_m1 = rslot - CntW'(1);
  assign raddr    = rslot_m1[AddrW-1:0];

  // Write select, always at the current position
  always_comb begin
    unique case (ctrl.wr)
      WR_HOLD: begin
        wr_en = 1'b1;
        wdata = hold_q;
      end
      WR_RD: begin
        wr_en = hit;
        wdata = rd_q;
      end
      WR_CAND: begin
        wr_en = hit;
        wdata = cand;
      end
      default: begin
        wr_en = 1'b0;
        wdata = hold_q;
      end
    endcase
  end
  assign wslot_m1 = pos_q - CntW'(1);
  assign waddr    = wslot_m1[AddrW-1:0];

  // Heap memory: one write and one registered read per cycle
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      heap_mem_q[waddr] <= wdata;
    end
    if (rd_en) begin
      rd_q <= heap_mem_q[raddr];
    end
  end

  // Count and position
  always_comb begin
    unique case (ctrl.cnt)
      CNT_INC: cnt_d = cnt_q + CntW'(1);
      CNT_DEC: cnt_d = cnt_q - CntW'(1);
      default: cnt_d = cnt_q;
    endcase
    unique case (ctrl.pos)
      POS_ONE:    pos_d = CntW'(1);
      POS_NEW:    pos_d = cnt_q + CntW'(1);
      POS_PARENT: pos_d = hit ? parent : pos_q;
      POS_CAND:   pos_d = hit ? cand_pos : pos_q;
      default:    pos_d = pos_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  // Working registers
  always_ff @(posedge clk_i) begin
    pos_q <= pos_d;
    if (start) begin
      req_q  <= req_e'(req_i.req_type);
      hold_q <= '{id: req_i.new_id, key: req_i.new_key};
    end else if (ctrl.hold_ld) begin
      hold_q <= rd_q;
    end
    if (ctrl.best_ld) begin
      best_q <= rd_q;
      bpos_q <= lchild;
    end
    // Root copy follows every write to slot one
    if (wr_en && (pos_q == CntW'(1))) begin
      root_q <= wdata;
    end
  end

  // Result fields built up while the item runs
  always_ff @(posedge clk_i) begin
    unique case (ctrl.res)
      RES_INIT: begin
        res_id_q  <= ID_NONE;
        res_key_q <= '0;
        res_st_q  <= ST_OK;
      end
      RES_ROOT: begin
        res_id_q  <= {1'b0, root_q.id};
        res_key_q <= root_q.key;
      end
      RES_FULL:  res_st_q <= ST_FULL;
      RES_EMPTY: res_st_q <= ST_EMPTY;
      default: ;
    endcase
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsp_valid_q <= 1'b0;
    end else if (ctrl.out_ld && hit) begin
      rsp_valid_q <= 1'b1;
    end else if (rsp_o.ready) begin
      rsp_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl.out_ld && hit) begin
      rsp_id_q  <= res_id_q;
      rsp_key_q <= res_key_q;
      rsp_st_q  <= res_st_q;
      rsp_cnt_q <= cnt_q;
      if (cnt_q == '0) begin
        rsp_peek_id_q  <= ID_NONE;
        rsp_peek_key_q <= '0;
      end else begin
        rsp_peek_id_q  <= {1'b0, root_q.id};
        rsp_peek_key_q <= root_q.key;
      end
    end
  end

  assign rsp_o.valid       = rsp_valid_q;
  assign rsp_o.out_id      = rsp_id_q;
  assign rsp_o.out_key     = rsp_key_q;
  assign rsp_o.status      = rsp_st_q;
  assign rsp_o.entry_count = CountW'(rsp_cnt_q);
  assign rsp_o.peek_id     = rsp_peek_id_q;
  assign rsp_o.peek_key    = rsp_peek_key_q;

endmodule

// ===== rtl/core/bhq_chk.sv =====
// Port-level checker for the binary min-heap queue, bound to the top level.
module bhq_chk #(
  parameter int unsigned CAPACITY = 1024
) (
  input logic                                    clk_i,
  input logic                                    rst_ni,
  input logic                                    rsp_valid_i,
  input logic                                    rsp_ready_i,
  input logic signed [bhq_pkg::OutW-1:0]         out_id_i,
  input logic [bhq_pkg::KeyW-1:0]                out_key_i,
  input logic [1:0]                              status_i,
  input logic [bhq_pkg::CountW-1:0]              entry_count_i,
  input logic signed [bhq_pkg::OutW-1:0]         peek_id_i,
  input logic [bhq_pkg::KeyW-1:0]                peek_key_i
);
  import bhq_pkg::*;

  // A stalled result word stays offered
  a_rsp_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !rsp_ready_i |=> rsp_valid_i)
    else $error("result word dropped while stalled");

  // Rejected insert only with a full heap and no entry returned
  a_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && (status_i == ST_FULL) |->
      (entry_count_i == CountW'(CAPACITY)) && (out_id_i == ID_NONE) && (out_key_i == '0))
    else $error("full status inconsistent");

  // Empty extract leaves an empty heap
  a_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && (status_i == ST_EMPTY) |->
      (entry_count_i == '0) && (out_id_i == ID_NONE) && (peek_id_i == ID_NONE))
    else $error("empty status inconsistent");

  // Peek shows no entry exactly when the count is zero
  a_peek: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i |-> ((entry_count_i == '0) == (peek_id_i == ID_NONE)))
    else $error("peek disagrees with count");

  // Extracted key never exceeds the new root key
  a_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && (status_i == ST_OK) && (out_id_i != ID_NONE) && (entry_count_i != '0)
      |-> (peek_key_i >= out_key_i))
    else $error("heap order violated");

endmodule

bind binary_min_heap_queue_top bhq_chk #(.CAPACITY(CAPACITY)) u_bhq_chk (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .rsp_valid_i   (rsp_o.valid),
  .rsp_ready_i   (rsp_o.ready),
  .out_id_i      (rsp_o.out_id),
  .out_key_i     (rsp_o.out_key),
  .status_i      (rsp_o.status),
  .entry_count_i (rsp_o.entry_count),
  .peek_id_i     (rsp_o.peek_id),
  .peek_key_i    (rsp_o.peek_key)
);
